// File: design/csv_fs_pkg.sv
`timescale 1ns / 1ps

package csv_fs_pkg;

    localparam int PEND_DEPTH_DEF = 16;
    // command count field covers the largest supported whitespace buffer (63)
    localparam int CNT_W          = 6;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [4:0] MAX_FIELDS_RST = 5'd5;
    localparam logic [4:0] FIELD_LIMIT    = 5'd16;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;

    localparam logic [2:0] REG_MAX_FIELDS = 3'd0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_MANY = 2'd1,
        ST_JUNK     = 2'd2,
        ST_WS_OVF   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_PUSH,   // store a held-back whitespace byte, no result
        CMD_EMIT,   // flush held whitespace, then one content byte
        CMD_END     // field or line end result
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       data;
        logic [CNT_W-1:0] cnt;      // push slot, or number of bytes to flush
        logic [3:0]       field;
        logic             line_end;
        t_status          status;
    } t_cmd;

endpackage

// File: design/csv_fs_front.sv
`timescale 1ns / 1ps

module csv_fs_front
    import csv_fs_pkg::*;
#(
    parameter int PEND_DEPTH = PEND_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    input  logic [4:0] i_max_fields,
    output logic       o_q_valid,
    input  logic       i_q_ready,
    output t_cmd       o_q_cmd
);

    localparam int CW = $clog2(PEND_DEPTH + 1);

    typedef enum logic [2:0] {
        M_START,
        M_LEAD,
        M_PLAIN,
        M_QUOTED,
        M_QSEEN,
        M_DONE
    } t_mode;

    t_mode         r_mode, n_mode;
    logic [3:0]    r_field, n_field;
    logic [CW-1:0] r_pend, n_pend;

    logic       accept;
    logic       cmd_valid;
    logic       end_fld;
    logic       end_ln;
    t_status    ln_st;
    logic [4:0] lim;
    logic [4:0] field_plus;
    logic       is_comma, is_eol, is_blank, is_quote;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_q_valid  = accept && cmd_valid;

    assign is_comma = (i_in_byte == CH_COMMA);
    assign is_quote = (i_in_byte == CH_QUOTE);
    assign is_eol   = (i_in_byte == CH_LF) || (i_in_byte == CH_CR);
    assign is_blank = (i_in_byte == CH_SP) || (i_in_byte == CH_TAB) ||
                      (i_in_byte == CH_VT) || (i_in_byte == CH_FF);

    // limit of zero acts as one, anything above sixteen as sixteen
    assign lim = (i_max_fields == 5'd0) ? 5'd1 :
                 (i_max_fields > FIELD_LIMIT) ? FIELD_LIMIT : i_max_fields;
    assign field_plus = {1'b0, r_field} + 5'd1;

    always_comb begin
        n_mode    = r_mode;
        n_field   = r_field;
        n_pend    = r_pend;
        cmd_valid = 1'b0;
        end_fld   = 1'b0;
        end_ln    = 1'b0;
        ln_st     = ST_OK;

        o_q_cmd.kind     = CMD_END;
        o_q_cmd.data     = i_in_byte;
        o_q_cmd.cnt      = '0;
        o_q_cmd.field    = r_field;
        o_q_cmd.line_end = 1'b1;
        o_q_cmd.status   = ST_OK;

        if (i_end_of_text) begin
            cmd_valid = (r_mode != M_DONE);
            n_mode    = M_START;
            n_field   = '0;
            n_pend    = '0;
        end else begin
            unique case (r_mode)
                M_START, M_LEAD: begin
                    if (is_comma) begin
                        end_fld = 1'b1;
                    end else if (is_eol) begin
                        end_ln = 1'b1;
                    end else if (is_blank) begin
                        n_mode = M_LEAD;
                    end else if (is_quote && r_mode == M_START) begin
                        n_mode = M_QUOTED;
                    end else begin
                        cmd_valid    = 1'b1;
                        o_q_cmd.kind = CMD_EMIT;
                        n_mode       = M_PLAIN;
                    end
                end
                M_PLAIN: begin
                    if (is_comma) begin
                        end_fld = 1'b1;
                    end else if (is_eol) begin
                        end_ln = 1'b1;
                    end else if (is_blank) begin
                        if (r_pend >= CW'(PEND_DEPTH)) begin
                            end_ln = 1'b1;
                            ln_st  = ST_WS_OVF;
                        end else begin
                            cmd_valid    = 1'b1;
                            o_q_cmd.kind = CMD_PUSH;
                            o_q_cmd.cnt  = CNT_W'(r_pend);
                            n_pend       = r_pend + CW'(1);
                        end
                    end else begin
                        cmd_valid    = 1'b1;
                        o_q_cmd.kind = CMD_EMIT;
                        o_q_cmd.cnt  = CNT_W'(r_pend);
                        n_pend       = '0;
                    end
                end
                M_QUOTED: begin
                    if (is_quote) begin
                        n_mode = M_QSEEN;
                    end else begin
                        cmd_valid    = 1'b1;
                        o_q_cmd.kind = CMD_EMIT;
                    end
                end
                M_QSEEN: begin
                    if (is_quote) begin
                        cmd_valid    = 1'b1;
                        o_q_cmd.kind = CMD_EMIT;
                        n_mode       = M_QUOTED;
                    end else if (is_comma) begin
                        end_fld = 1'b1;
                    end else if (is_eol) begin
                        end_ln = 1'b1;
                    end else begin
                        end_ln = 1'b1;
                        ln_st  = ST_JUNK;
                    end
                end
                M_DONE: begin
                end
                default: begin
                    n_mode = M_DONE;
                end
            endcase

            if (end_fld) begin
                if (field_plus >= lim) begin
                    end_ln = 1'b1;
                    ln_st  = ST_TOO_MANY;
                end else begin
                    cmd_valid        = 1'b1;
                    o_q_cmd.line_end = 1'b0;
                    n_field          = r_field + 4'd1;
                    n_pend           = '0;
                    n_mode           = M_START;
                end
            end

            if (end_ln) begin
                cmd_valid        = 1'b1;
                o_q_cmd.kind     = CMD_END;
                o_q_cmd.line_end = 1'b1;
                o_q_cmd.status   = ln_st;
                n_mode           = M_DONE;
                n_pend           = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_field <= '0;
            r_pend  <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_field <= n_field;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: design/csv_fs_queue.sv
`timescale 1ns / 1ps

module csv_fs_queue
    import csv_fs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_cmd,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_cmd o_rd_cmd
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;

    logic do_wr, do_rd;

    assign o_wr_ready = (r_count != NW'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];

    assign do_wr = i_wr_valid && o_wr_ready;
    assign do_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + NW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

// File: design/csv_fs_back.sv
`timescale 1ns / 1ps

module csv_fs_back
    import csv_fs_pkg::*;
#(
    parameter int PEND_DEPTH = PEND_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    output logic       o_q_ready,
    input  t_cmd       i_q_cmd,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic [3:0] o_field_number,
    output logic       o_field_end,
    output logic       o_line_end,
    output logic [1:0] o_status,
    output logic       o_run_last
);

    localparam int AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int CW = $clog2(PEND_DEPTH + 1);

    typedef enum logic [1:0] {
        S_RUN,
        S_FLUSH,
        S_TAIL
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_k, n_k;

    logic [7:0]    r_pend_mem [PEND_DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    logic          r_o_valid;
    logic [7:0]    r_o_byte;
    logic          r_o_bvalid;
    logic [3:0]    r_o_field;
    logic          r_o_fend;
    logic          r_o_lend;
    t_status       r_o_status;
    logic          r_o_last;

    logic          out_free;
    logic          pop;
    logic          load;
    logic [CW-1:0] flush_n;
    logic [7:0]    ld_byte;
    logic          ld_bvalid;
    logic          ld_fend;
    logic          ld_lend;
    t_status       ld_status;
    logic          ld_last;

    assign out_free  = !r_o_valid || i_out_ready;
    assign o_q_ready = pop;
    assign flush_n   = i_q_cmd.cnt[CW-1:0];

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        rd_addr   = r_k[AW-1:0];
        mem_we    = 1'b0;
        pop       = 1'b0;
        load      = 1'b0;
        ld_byte   = i_q_cmd.data;
        ld_bvalid = 1'b1;
        ld_fend   = 1'b0;
        ld_lend   = 1'b0;
        ld_status = ST_OK;
        ld_last   = 1'b1;

        unique case (r_state)
            S_RUN: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        CMD_PUSH: begin
                            mem_we = 1'b1;
                            pop    = 1'b1;
                        end
                        CMD_EMIT: begin
                            if (flush_n == '0) begin
                                if (out_free) begin
                                    load = 1'b1;
                                    pop  = 1'b1;
                                end
                            end else begin
                                // first held byte is read while entering the flush
                                n_state = S_FLUSH;
                                n_k     = '0;
                                rd_addr = '0;
                            end
                        end
                        CMD_END: begin
                            ld_byte   = 8'h00;
                            ld_bvalid = 1'b0;
                            ld_fend   = 1'b1;
                            ld_lend   = i_q_cmd.line_end;
                            ld_status = i_q_cmd.status;
                            if (out_free) begin
                                load = 1'b1;
                                pop  = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                ld_byte = r_rd_data;
                ld_last = 1'b0;
                if (out_free) begin
                    load = 1'b1;
                    if (r_k + CW'(1) == flush_n) begin
                        n_state = S_TAIL;
                    end else begin
                        n_k     = r_k + CW'(1);
                        rd_addr = n_k[AW-1:0];
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    load    = 1'b1;
                    pop     = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pend_mem[i_q_cmd.cnt[AW-1:0]] <= i_q_cmd.data;
        end
        r_rd_data <= r_pend_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (load) begin
                r_o_valid  <= 1'b1;
                r_o_byte   <= ld_byte;
                r_o_bvalid <= ld_bvalid;
                r_o_field  <= i_q_cmd.field;
                r_o_fend   <= ld_fend;
                r_o_lend   <= ld_lend;
                r_o_status <= ld_status;
                r_o_last   <= ld_last;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_byte_valid   = r_o_bvalid;
    assign o_field_number = r_o_field;
    assign o_field_end    = r_o_fend;
    assign o_line_end     = r_o_lend;
    assign o_status       = r_o_status;
    assign o_run_last     = r_o_last;

endmodule

// File: design/csv_field_splitter_core.sv
`timescale 1ns / 1ps
// Path: an item passes through the command queue and the registered result stage;
//   held whitespace that has to be flushed ahead of it goes through the buffer read register.
// Throughput: one item per cycle while the command queue has room; a content byte behind
//   n held whitespace bytes occupies the result sequencer for one buffer read each, then its own result.
// Reset: synchronous, active low; clears parser, command queue, output valid
//   and sets max_fields to 5. The whitespace buffer is not cleared.

module csv_field_splitter_core
    import csv_fs_pkg::*;
#(
    parameter int PEND_DEPTH = PEND_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic [3:0]  o_field_number,
    output logic        o_field_end,
    output logic        o_line_end,
    output logic [1:0]  o_status,
    output logic        o_run_last
);

    logic [4:0] r_max_fields;
    logic       q_wr_valid, q_wr_ready;
    t_cmd       q_wr_cmd;
    logic       q_rd_valid, q_rd_ready;
    t_cmd       q_rd_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MAX_FIELDS) ? {27'd0, r_max_fields} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields <= MAX_FIELDS_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_FIELDS[2]) begin
            r_max_fields <= pwdata[4:0];
        end
    end

    csv_fs_front #(
        .PEND_DEPTH (PEND_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_max_fields  (r_max_fields),
        .o_q_valid     (q_wr_valid),
        .i_q_ready     (q_wr_ready),
        .o_q_cmd       (q_wr_cmd)
    );

    csv_fs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (q_wr_valid),
        .o_wr_ready (q_wr_ready),
        .i_wr_cmd   (q_wr_cmd),
        .o_rd_valid (q_rd_valid),
        .i_rd_ready (q_rd_ready),
        .o_rd_cmd   (q_rd_cmd)
    );

    csv_fs_back #(
        .PEND_DEPTH (PEND_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_rd_valid),
        .o_q_ready      (q_rd_ready),
        .i_q_cmd        (q_rd_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_field_number (o_field_number),
        .o_field_end    (o_field_end),
        .o_line_end     (o_line_end),
        .o_status       (o_status),
        .o_run_last     (o_run_last)
    );

endmodule

// File: design/csv_fs_checker.sv
`timescale 1ns / 1ps

module csv_fs_checker
    import csv_fs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic [3:0] o_field_number,
    input logic       o_field_end,
    input logic       o_line_end,
    input logic [1:0] o_status,
    input logic       o_run_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) &&
        $stable(o_field_number) && $stable(o_field_end) && $stable(o_line_end) &&
        $stable(o_status) && $stable(o_run_last) && $stable(o_byte_valid))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // error results close field and line and carry no byte
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
        o_field_end && o_line_end && !o_byte_valid && o_run_last)
        else $error("malformed error result");

    // content bytes never close anything; end markers carry a zero byte
    a_byte_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_valid ? (!o_field_end && !o_line_end) :
                                        (o_out_byte == 8'h00 && o_field_end)))
        else $error("content byte and end marker mixed");

endmodule

bind csv_field_splitter_core csv_fs_checker u_csv_fs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_out_byte     (o_out_byte),
    .o_byte_valid   (o_byte_valid),
    .o_field_number (o_field_number),
    .o_field_end    (o_field_end),
    .o_line_end     (o_line_end),
    .o_status       (o_status),
    .o_run_last     (o_run_last)
);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import csv_fs_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_ITEMS    = 300;
    localparam int LIMIT_PHASES  = 6;

    typedef enum logic [2:0] {
        PM_START,
        PM_LEAD,
        PM_PLAIN,
        PM_QUOTED,
        PM_QSEEN,
        PM_DONE
    } t_parse_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic [3:0] field;
        logic       field_end;
        logic       line_end;
        t_status    status;
        logic       last;
    } t_field_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = '0;
    logic        i_end_of_text = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic [3:0]  o_field_number;
    logic        o_field_end;
    logic        o_line_end;
    logic [1:0]  o_status;
    logic        o_run_last;

    // splitter state as predicted
    t_parse_mode parse_mode;
    logic [4:0]  field_cnt;
    logic [7:0]  held_ws [PEND_DEPTH_DEF];
    int          held_cnt;
    logic [4:0]  field_limit;

    t_field_event item_events[$];
    t_field_event expected_events[$];

    int err_count  = 0;
    int live_items = 0;
    int burst_left = 0;
    int hold_left  = 0;
    int rx_phase   = 0;
    int rx_mode    = 0;
    int rx_tick    = 0;
    int cycle_cnt  = 0;
    bit tx_gaps_on = 1'b1;

    csv_field_splitter_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_field_number (o_field_number),
        .o_field_end    (o_field_end),
        .o_line_end     (o_line_end),
        .o_status       (o_status),
        .o_run_last     (o_run_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    function automatic bit is_eol(logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic int clamped_limit();
        if (field_limit < 5'd1) return 1;
        if (field_limit > FIELD_LIMIT) return 16;
        return int'(field_limit);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 3))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // any byte with no meaning to the parser
    function automatic logic [7:0] rand_text();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_COMMA || c == CH_QUOTE || is_eol(c) || is_blank(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic add_event(logic [7:0] data, logic dv, logic fe, logic le, t_status st);
        t_field_event ev;
        ev.data       = data;
        ev.data_valid = dv;
        ev.field      = field_cnt[3:0];
        ev.field_end  = fe;
        ev.line_end   = le;
        ev.status     = st;
        ev.last       = 1'b0;
        item_events.push_back(ev);
    endtask

    task automatic close_line(t_status st);
        add_event(8'h00, 1'b0, 1'b1, 1'b1, st);
        parse_mode = PM_DONE;
        held_cnt   = 0;
    endtask

    task automatic close_field();
        if (int'(field_cnt) + 1 >= clamped_limit()) begin
            close_line(ST_TOO_MANY);
        end else begin
            add_event(8'h00, 1'b0, 1'b1, 1'b0, ST_OK);
            field_cnt++;
            held_cnt   = 0;
            parse_mode = PM_START;
        end
    endtask

    task automatic predict_split(logic [7:0] b, logic eot);
        item_events.delete();
        live_items++;
        if (eot) begin
            if (parse_mode != PM_DONE)
                add_event(8'h00, 1'b0, 1'b1, 1'b1, ST_OK);
            parse_mode = PM_START;
            field_cnt  = '0;
            held_cnt   = 0;
        end else begin
            case (parse_mode)
                PM_START, PM_LEAD: begin
                    if (b == CH_COMMA)
                        close_field();
                    else if (is_eol(b))
                        close_line(ST_OK);
                    else if (is_blank(b))
                        parse_mode = PM_LEAD;
                    else if (b == CH_QUOTE && parse_mode == PM_START)
                        parse_mode = PM_QUOTED;
                    else begin
                        add_event(b, 1'b1, 1'b0, 1'b0, ST_OK);
                        parse_mode = PM_PLAIN;
                    end
                end
                PM_PLAIN: begin
                    if (b == CH_COMMA) begin
                        close_field();
                    end else if (is_eol(b)) begin
                        close_line(ST_OK);
                    end else if (is_blank(b)) begin
                        if (held_cnt >= PEND_DEPTH_DEF)
                            close_line(ST_WS_OVF);
                        else
                            held_ws[held_cnt++] = b;
                    end else begin
                        for (int k = 0; k < held_cnt; k++)
                            add_event(held_ws[k], 1'b1, 1'b0, 1'b0, ST_OK);
                        held_cnt = 0;
                        add_event(b, 1'b1, 1'b0, 1'b0, ST_OK);
                    end
                end
                PM_QUOTED: begin
                    if (b == CH_QUOTE)
                        parse_mode = PM_QSEEN;
                    else
                        add_event(b, 1'b1, 1'b0, 1'b0, ST_OK);
                end
                PM_QSEEN: begin
                    if (b == CH_QUOTE) begin
                        add_event(b, 1'b1, 1'b0, 1'b0, ST_OK);
                        parse_mode = PM_QUOTED;
                    end else if (b == CH_COMMA) begin
                        close_field();
                    end else if (is_eol(b)) begin
                        close_line(ST_OK);
                    end else begin
                        close_line(ST_JUNK);
                    end
                end
                default: parse_mode = PM_DONE;
            endcase
        end
        if (item_events.size() > 0)
            item_events[item_events.size() - 1].last = 1'b1;
        foreach (item_events[k])
            expected_events.push_back(item_events[k]);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= 40)
            $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    endtask

    // bursts of back-to-back items with random gaps in between
    task automatic send_byte(logic [7:0] b, logic eot);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap        = tx_gaps_on ? $urandom_range(0, 8) : 0;
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_split(b, eot);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], 1'b0);
    endtask

    task automatic end_text();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_events.size() != 0) @(posedge i_clk);
        // items without results may still be in the command queue
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_field_limit(logic [4:0] value);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MAX_FIELDS << 2;
        pwdata  <= {27'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        field_limit = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_plain_field();
        int n_tok;
        bit started;
        started = 1'b0;
        repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
        n_tok = $urandom_range(0, 4);
        for (int t = 0; t < n_tok; t++) begin
            if (t > 0) begin
                // now and then a run long enough to fill or overflow the buffer
                if ($urandom_range(0, 11) == 0)
                    repeat ($urandom_range(14, 17)) send_byte(rand_blank(), 1'b0);
                else
                    repeat ($urandom_range(1, 3)) send_byte(rand_blank(), 1'b0);
            end
            repeat ($urandom_range(1, 3)) begin
                if (started && $urandom_range(0, 9) == 0)
                    send_byte(CH_QUOTE, 1'b0);
                else
                    send_byte(rand_text(), 1'b0);
                started = 1'b1;
            end
        end
        repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
    endtask

    task automatic send_quoted_field(bit close_it);
        logic [7:0] c;
        send_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0: c = CH_COMMA;
                1: c = CH_LF;
                2: c = CH_CR;
                3: c = CH_QUOTE;
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_byte(c, 1'b0);
            if (c == CH_QUOTE)
                send_byte(CH_QUOTE, 1'b0);
        end
        if (close_it) begin
            send_byte(CH_QUOTE, 1'b0);
            if ($urandom_range(0, 14) == 0)
                send_byte(rand_text(), 1'b0);
        end
    endtask

    task automatic send_random_line();
        int  n_fields;
        bit  open_quote;
        open_quote = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            // raw noise, including stray end-of-text
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end_text();
            return;
        end
        n_fields = $urandom_range(1, clamped_limit());
        if ($urandom_range(0, 5) == 0)
            n_fields = clamped_limit() + $urandom_range(1, 2);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0)
                send_byte(CH_COMMA, 1'b0);
            case ($urandom_range(0, 4))
                0: ;
                1, 2: send_plain_field();
                default: begin
                    open_quote = (f == n_fields - 1) && ($urandom_range(0, 7) == 0);
                    send_quoted_field(!open_quote);
                end
            endcase
        end
        if (!open_quote) begin
            case ($urandom_range(0, 4))
                0: ;
                1: send_byte(CH_LF, 1'b0);
                2: begin
                    send_byte(CH_CR, 1'b0);
                    send_byte(CH_LF, 1'b0);
                end
                3: send_byte(CH_CR, 1'b0);
                default: begin
                    send_byte(CH_LF, 1'b0);
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            endcase
        end
        end_text();
    endtask

    task automatic test_quoting_and_trim();
        send_text(" a\tb ,\"q,\"\"\n\",");
        end_text();
    endtask

    task automatic test_line_ends();
        end_text();
        send_text("\r\nx");
        end_text();
        send_text("\"a\"x");
        end_text();
    endtask

    task automatic test_literal_quotes_and_extremes();
        send_text(" \"");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text("\"\n");
        end_text();
    endtask

    task automatic test_field_limit();
        send_text(",,,,,");
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_blank_overflow();
        send_text("a");
        repeat (PEND_DEPTH_DEF + 1) send_byte(rand_blank(), 1'b0);
        send_text("\"open");
        end_text();
        send_text("\"open");
        send_byte(8'h00, 1'b1);
    endtask

    // receiver holds off while a long quoted field keeps coming
    task automatic test_output_backpressure();
        wait_drained();
        tx_gaps_on = 1'b0;
        hold_left  = 300;
        send_byte(CH_QUOTE, 1'b0);
        repeat (40) send_byte(rand_text(), 1'b0);
        end_text();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_lines();
        int start;
        logic [4:0] lim;
        for (int k = 0; k < LIMIT_PHASES; k++) begin
            case (k)
                0: lim = 5'd16;
                1: lim = 5'd1;
                2: lim = 5'd0;
                3: lim = 5'd31;
                4: lim = 5'd7;
                default: lim = 5'($urandom_range(2, 15));
            endcase
            write_field_limit(lim);
            tx_gaps_on = (k != 3);
            start = live_items;
            while (live_items - start < RAND_ITEMS / LIMIT_PHASES)
                send_random_line();
        end
        tx_gaps_on = 1'b1;
    endtask

    // receiver: changes its stall pattern every so often
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                if (rx_phase == 0) begin
                    rx_mode  = $urandom_range(0, 3);
                    rx_phase = $urandom_range(20, 200);
                end
                rx_phase--;
                rx_tick++;
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= (rx_tick % 4) == 0;
                    default: i_out_ready <= (rx_tick % 7) != 3;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_field_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("result with nothing expected, out_byte", o_out_byte, 0);
            end else begin
                want = expected_events.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", o_out_byte, want.data);
                if (o_byte_valid !== want.data_valid)
                    report_mismatch("byte_valid", o_byte_valid, want.data_valid);
                if (o_field_number !== want.field)
                    report_mismatch("field_number", o_field_number, want.field);
                if (o_field_end !== want.field_end)
                    report_mismatch("field_end", o_field_end, want.field_end);
                if (o_line_end !== want.line_end)
                    report_mismatch("line_end", o_line_end, want.line_end);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_run_last !== want.last)
                    report_mismatch("run_last", o_run_last, want.last);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("csv_field_splitter_core test failed");
        $finish;
    end

    initial begin
        parse_mode  = PM_START;
        field_cnt   = '0;
        held_cnt    = 0;
        field_limit = MAX_FIELDS_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_quoting_and_trim();
        test_line_ends();
        test_literal_quotes_and_extremes();
        test_field_limit();
        test_blank_overflow();
        test_output_backpressure();
        test_random_lines();
        wait_drained();

        if (err_count == 0)
            $display("csv_field_splitter_core test passed");
        else
            $display("csv_field_splitter_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
design/csv_fs_pkg.sv
design/csv_fs_front.sv
design/csv_fs_queue.sv
design/csv_fs_back.sv
design/csv_field_splitter_core.sv
design/csv_fs_checker.sv
sim/tb_top.sv
